// File: design/irfd_pkg.sv
// shared types and constants of the infrared remote frame decoder
package irfd_pkg;

   // data bits in one frame, lsb first
   localparam logic [5:0] FrameBits = 6'd32;

   // depth of the small queues between and after the two halves
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // inclusive pulse timing windows, microseconds
   localparam logic [15:0] LeaderLo    = 16'd8440;
   localparam logic [15:0] LeaderHi    = 16'd9560;
   localparam logic [15:0] LongSpLo    = 16'd4000;
   localparam logic [15:0] LongSpHi    = 16'd5000;
   localparam logic [15:0] RepSpLo     = 16'd1850;
   localparam logic [15:0] RepSpHi     = 16'd2650;
   localparam logic [15:0] MarkLo      = 16'd210;
   localparam logic [15:0] MarkHi      = 16'd910;
   localparam logic [15:0] OneSpLo     = 16'd1340;
   localparam logic [15:0] OneSpHi     = 16'd2040;
   localparam logic [15:0] ZeroSpLo    = 16'd210;
   localparam logic [15:0] ZeroSpHi    = 16'd910;

   localparam logic [7:0] ByteInvert = 8'hFF;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEADER = 3'd1,
      PH_MARK   = 3'd2,
      PH_SPACE  = 3'd3,
      PH_REPEAT = 3'd4
   } phase_type;

   // what one edge looks like once polarity and timing are checked
   typedef struct packed {
      logic leader;
      logic long_space;
      logic rep_space;
      logic mark;
      logic one_space;
      logic zero_space;
   } class_type;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] command_code;
      logic       repeat_res;
   } result_type;

endpackage

// File: design/irfd_front.sv
// front half: polarity register, edge classification and the class queue
module irfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 push,
   input  logic                 raw_level,
   input  logic [15:0]          duration_us,
   output logic                 full,
   input  logic                 cls_pop,
   output logic                 cls_valid,
   output irfd_pkg::class_type  cls
);

   logic                              active_high_ff, active_high_in;
   irfd_pkg::class_type               mem_ff [irfd_pkg::QueueDepth];
   logic [irfd_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [irfd_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [irfd_pkg::QueueCntW-1:0]    count_ff, count_in;
   irfd_pkg::class_type               cls_new;
   logic                              act;
   logic                              do_push;
   logic                              do_pop;

   function automatic logic in_win(input logic [15:0] d, input logic [15:0] lo,
                                   input logic [15:0] hi);
      in_win = (d >= lo) && (d <= hi);
   endfunction

   always_comb begin
      act = (raw_level == active_high_ff);
      cls_new.leader     = act  && in_win(duration_us, irfd_pkg::LeaderLo, irfd_pkg::LeaderHi);
      cls_new.long_space = !act && in_win(duration_us, irfd_pkg::LongSpLo, irfd_pkg::LongSpHi);
      cls_new.rep_space  = !act && in_win(duration_us, irfd_pkg::RepSpLo, irfd_pkg::RepSpHi);
      cls_new.mark       = act  && in_win(duration_us, irfd_pkg::MarkLo, irfd_pkg::MarkHi);
      cls_new.one_space  = !act && in_win(duration_us, irfd_pkg::OneSpLo, irfd_pkg::OneSpHi);
      cls_new.zero_space = !act && in_win(duration_us, irfd_pkg::ZeroSpLo, irfd_pkg::ZeroSpHi);
   end

   assign full      = (count_ff == irfd_pkg::QueueCntW'(irfd_pkg::QueueDepth));
   assign cls_valid = (count_ff != '0);
   assign cls       = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cls_pop && cls_valid;

   always_comb begin
      active_high_in = csr_we ? csr_wdata : active_high_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + irfd_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + irfd_pkg::QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + irfd_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - irfd_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= 1'b1;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         active_high_ff <= active_high_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cls_new;
      end
   end

endmodule

// File: design/irfd_back.sv
// back half: frame phase machine, bit collection and the result queue
module irfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cls_valid,
   input  irfd_pkg::class_type  cls,
   output logic                 cls_pop,
   output logic                 empty,
   input  logic                 pop,
   output irfd_pkg::result_type res
);

   irfd_pkg::phase_type               phase_ff, phase_in;
   logic [5:0]                        bit_count_ff, bit_count_in;
   logic [31:0]                       shift_word_ff, shift_word_in;
   logic [7:0]                        last_address_ff, last_address_in;
   logic [7:0]                        last_command_ff, last_command_in;
   irfd_pkg::result_type              mem_ff [irfd_pkg::QueueDepth];
   logic [irfd_pkg::QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [irfd_pkg::QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [irfd_pkg::QueueCntW-1:0]    count_ff, count_in;
   irfd_pkg::result_type              res_new;
   logic                              emit;
   logic                              take;
   logic                              do_pop;
   logic                              checks_ok;

   // one item a cycle as long as the result queue has room
   assign take   = cls_valid && (count_ff != irfd_pkg::QueueCntW'(irfd_pkg::QueueDepth));
   assign cls_pop = take;
   assign empty  = (count_ff == '0);
   assign res    = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   assign checks_ok = ((shift_word_ff[7:0] ^ shift_word_ff[15:8]) == irfd_pkg::ByteInvert) &&
                      ((shift_word_ff[23:16] ^ shift_word_ff[31:24]) == irfd_pkg::ByteInvert);

   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      shift_word_in   = shift_word_ff;
      last_address_in = last_address_ff;
      last_command_in = last_command_ff;
      emit            = 1'b0;
      res_new.address      = last_address_ff;
      res_new.command_code = last_command_ff;
      res_new.repeat_res   = 1'b1;
      if (take) begin
         if (cls.leader) begin
            phase_in = irfd_pkg::PH_LEADER;
         end else begin
            case (phase_ff)
               irfd_pkg::PH_IDLE: begin
                  phase_in = irfd_pkg::PH_IDLE;
               end
               irfd_pkg::PH_LEADER: begin
                  if (cls.long_space) begin
                     bit_count_in  = '0;
                     shift_word_in = '0;
                     phase_in      = irfd_pkg::PH_MARK;
                  end else if (cls.rep_space) begin
                     phase_in = irfd_pkg::PH_REPEAT;
                  end
               end
               irfd_pkg::PH_REPEAT: begin
                  if (cls.mark) begin
                     phase_in = irfd_pkg::PH_IDLE;
                     emit     = 1'b1;
                  end
               end
               irfd_pkg::PH_MARK: begin
                  if (cls.mark) begin
                     if (bit_count_ff >= irfd_pkg::FrameBits) begin
                        // closing mark: frame goes idle pass or fail
                        phase_in = irfd_pkg::PH_IDLE;
                        if (checks_ok) begin
                           last_address_in      = shift_word_ff[7:0];
                           last_command_in      = shift_word_ff[23:16];
                           res_new.address      = shift_word_ff[7:0];
                           res_new.command_code = shift_word_ff[23:16];
                           res_new.repeat_res   = 1'b0;
                           emit                 = 1'b1;
                        end
                     end else begin
                        phase_in = irfd_pkg::PH_SPACE;
                     end
                  end
               end
               irfd_pkg::PH_SPACE: begin
                  if (cls.one_space) begin
                     if (bit_count_ff < irfd_pkg::FrameBits) begin
                        shift_word_in[bit_count_ff[4:0]] = 1'b1;
                     end
                     bit_count_in = bit_count_ff + 6'd1;
                     phase_in     = irfd_pkg::PH_MARK;
                  end else if (cls.zero_space) begin
                     bit_count_in = bit_count_ff + 6'd1;
                     phase_in     = irfd_pkg::PH_MARK;
                  end
               end
               default: begin
                  phase_in = irfd_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      wr_ptr_in = emit ? wr_ptr_ff + irfd_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + irfd_pkg::QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (emit && !do_pop) begin
         count_in = count_ff + irfd_pkg::QueueCntW'(1);
      end else if (do_pop && !emit) begin
         count_in = count_ff - irfd_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= irfd_pkg::PH_IDLE;
         bit_count_ff    <= '0;
         shift_word_ff   <= '0;
         last_address_ff <= '0;
         last_command_ff <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         shift_word_ff   <= shift_word_in;
         last_address_ff <= last_address_in;
         last_command_ff <= last_command_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         mem_ff[wr_ptr_ff] <= res_new;
      end
   end

endmodule

// File: design/ir_remote_frame_decoder.sv
// top level of the infrared remote frame decoder: front and back halves joined by a queue
// a result shows on the rsp_ ports once the edge item that completes it has passed the class queue and the result queue
// throughput: one edge item per cycle while the result queue has room, set by the phase step in the back half
// both halves own a two-entry queue, so either side may stall without stopping the other
// reset (synchronous, active high): queues empty, phase idle, bits and stored pair zero,
// polarity back to active high
module ir_remote_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   // edge items in
   input  logic        push,
   output logic        full,
   input  logic        req_raw_level,
   input  logic [15:0] req_duration_us,
   // decoded items out
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_address,
   output logic [7:0]  rsp_command_code,
   output logic        rsp_repeat_res,
   // polarity register
   input  logic        csr_we,
   input  logic        csr_wdata
);

   // classified edge between the halves
   irfd_pkg::class_type  cls;
   logic                 cls_valid;
   logic                 cls_pop;
   irfd_pkg::result_type res;

   // front: polarity compare and timing windows, one item per cycle into its queue while not full
   irfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .raw_level   (req_raw_level),
      .duration_us (req_duration_us),
      .full        (full),
      .cls_pop     (cls_pop),
      .cls_valid   (cls_valid),
      .cls         (cls)
   );

   // back: leader / data / repeat phases, byte checks, result queue
   irfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cls_valid (cls_valid),
      .cls       (cls),
      .cls_pop   (cls_pop),
      .empty     (empty),
      .pop       (pop),
      .res       (res)
   );

   // unpack the waiting result item
   assign rsp_address      = res.address;
   assign rsp_command_code = res.command_code;
   assign rsp_repeat_res   = res.repeat_res;

endmodule

// File: design/irfd_checker.sv
// port-level checks of the infrared remote frame decoder and their bind
module irfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_address,
   input logic [7:0]  rsp_command_code,
   input logic        rsp_repeat_res
);

   // reset leaves both queues empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // the input queue only fills through a push
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(req_push))
      else $error("full rose without a push");

   // the result queue only drains through a pop
   a_empty_needs_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(empty) |-> ($past(pop) || $past(reset)))
      else $error("result item lost without a pop");

   // a waiting result item holds until taken
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_address) &&
                            $stable(rsp_command_code) && $stable(rsp_repeat_res)))
      else $error("waiting result item changed");

endmodule

bind ir_remote_frame_decoder irfd_checker u_irfd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (push),
   .full             (full),
   .empty            (empty),
   .pop              (pop),
   .rsp_address      (rsp_address),
   .rsp_command_code (rsp_command_code),
   .rsp_repeat_res   (rsp_repeat_res)
);
